// File: rtl/core/ttp_pkg.sv
// ----------------------------------------------------------------------------
// ttp_pkg
// Shared types and constants of the transposition table probe.
// ----------------------------------------------------------------------------
package ttp_pkg;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned INDEX_W       = $clog2(TABLE_ENTRIES);

  localparam int unsigned KEY_W   = 64;
  localparam int unsigned SCORE_W = 16;
  localparam int unsigned DEPTH_W = 6;
  localparam int unsigned MOVE_W  = 16;
  localparam int unsigned BOUND_W = 2;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
  localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
  localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [SCORE_W-1:0] score;
    logic [DEPTH_W-1:0] depth;
    logic [MOVE_W-1:0]  move;
    logic [BOUND_W-1:0] bound;
  } ttp_slot_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK
  } ttp_state_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic check;
  } ttp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ttp_status_t;

endpackage

// File: rtl/core/ttp_ctrl.sv
// ----------------------------------------------------------------------------
// ttp_ctrl
// Sequencer: clearing sweep after reset, item acceptance, lookup check step.
// ----------------------------------------------------------------------------
module ttp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 operation,
  input  ttp_pkg::ttp_status_t status,
  output ttp_pkg::ttp_cmd_t    cmd,
  output logic                 busy
);
  import ttp_pkg::*;

  ttp_state_t state;
  ttp_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        // a store finishes at the accept edge; a lookup needs the check step
        if (start && (operation == OP_LOOKUP)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/core/ttp_datapath.sv
// ----------------------------------------------------------------------------
// ttp_datapath
// Slot memory, clear counter, request registers, hit test and result registers.
// ----------------------------------------------------------------------------
module ttp_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ttp_pkg::ttp_cmd_t                     cmd,
  output ttp_pkg::ttp_status_t                  status,
  input  logic                                  operation,
  input  logic [ttp_pkg::KEY_W-1:0]             position_key,
  input  logic signed [ttp_pkg::SCORE_W-1:0]    entry_score,
  input  logic [ttp_pkg::DEPTH_W-1:0]           entry_depth,
  input  logic [ttp_pkg::MOVE_W-1:0]            entry_move,
  input  logic [ttp_pkg::BOUND_W-1:0]           bound_kind,
  input  logic [ttp_pkg::DEPTH_W-1:0]           needed_depth,
  input  logic signed [ttp_pkg::SCORE_W-1:0]    window_low,
  input  logic signed [ttp_pkg::SCORE_W-1:0]    window_high,
  output logic                                  done,
  output logic                                  hit,
  output logic signed [ttp_pkg::SCORE_W-1:0]    found_score,
  output logic [ttp_pkg::MOVE_W-1:0]            found_move,
  output logic [ttp_pkg::DEPTH_W-1:0]           found_depth
);
  import ttp_pkg::*;

  ttp_slot_t mem [TABLE_ENTRIES];
  ttp_slot_t rdata;

  logic [INDEX_W-1:0] clear_idx;
  logic [INDEX_W-1:0] slot_idx;

  logic [KEY_W-1:0]          req_key;
  logic [DEPTH_W-1:0]        req_need;
  logic signed [SCORE_W-1:0] req_low;
  logic signed [SCORE_W-1:0] req_high;

  logic signed [SCORE_W-1:0] stored_score;
  logic                      bound_ok;
  logic                      hit_next;

  assign slot_idx          = position_key[INDEX_W-1:0];
  assign status.clear_last = (clear_idx == {INDEX_W{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
    end else if (cmd.clear_en) begin
      clear_idx <= clear_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[clear_idx] <= '0;
    end else if (cmd.accept && (operation == OP_STORE)) begin
      mem[slot_idx] <= '{key:   position_key,
                         score: entry_score,
                         depth: entry_depth,
                         move:  entry_move,
                         bound: bound_kind};
    end
    if (cmd.accept) begin
      rdata <= mem[slot_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_key  <= position_key;
      req_need <= needed_depth;
      req_low  <= window_low;
      req_high <= window_high;
    end
  end

  assign stored_score = rdata.score;

  always_comb begin
    unique case (rdata.bound)
      BOUND_EXACT: bound_ok = 1'b1;
      BOUND_LOWER: bound_ok = (stored_score >= req_high);
      BOUND_UPPER: bound_ok = (stored_score <= req_low);
      default:     bound_ok = 1'b0;
    endcase
  end

  assign hit_next = (rdata.key == req_key) && (rdata.depth >= req_need) &&
                    (stored_score != '0) && bound_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= cmd.check;
      if (cmd.check) begin
        hit <= hit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      found_score <= hit_next ? stored_score : '0;
      found_move  <= hit_next ? rdata.move   : '0;
      found_depth <= hit_next ? rdata.depth  : '0;
    end
  end

endmodule

// File: rtl/core/transposition_table_probe.sv
// ----------------------------------------------------------------------------
// transposition_table_probe
// Direct-mapped table of search results: store items write a slot, lookup
// items read it and report whether the entry is usable.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  --------  -----------------  ---------------------------------------------
//  request   start && !busy     operation, position_key, entry_*, bound_kind,
//                               needed_depth, window_low, window_high
//  result    done (one cycle)   hit, found_score, found_move, found_depth
//
//  A store ends at the accept edge; a lookup adds the check step: the slot
//  memory read port is registered, then the hit test runs and the result
//  shows with done in the cycle after, when the next item may already be
//  accepted. After reset busy stays high while the slot memory is swept to
//  zero, one slot per cycle.
//  The receiver cannot stall; each result stands for exactly one cycle.
// ----------------------------------------------------------------------------
module transposition_table_probe (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  operation,
  input  logic [ttp_pkg::KEY_W-1:0]             position_key,
  input  logic signed [ttp_pkg::SCORE_W-1:0]    entry_score,
  input  logic [ttp_pkg::DEPTH_W-1:0]           entry_depth,
  input  logic [ttp_pkg::MOVE_W-1:0]            entry_move,
  input  logic [ttp_pkg::BOUND_W-1:0]           bound_kind,
  input  logic [ttp_pkg::DEPTH_W-1:0]           needed_depth,
  input  logic signed [ttp_pkg::SCORE_W-1:0]    window_low,
  input  logic signed [ttp_pkg::SCORE_W-1:0]    window_high,
  output logic                                  done,
  output logic                                  hit,
  output logic signed [ttp_pkg::SCORE_W-1:0]    found_score,
  output logic [ttp_pkg::MOVE_W-1:0]            found_move,
  output logic [ttp_pkg::DEPTH_W-1:0]           found_depth
);
  import ttp_pkg::*;

  ttp_cmd_t    cmd;
  ttp_status_t status;

  ttp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy)
  );

  ttp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .operation    (operation),
    .position_key (position_key),
    .entry_score  (entry_score),
    .entry_depth  (entry_depth),
    .entry_move   (entry_move),
    .bound_kind   (bound_kind),
    .needed_depth (needed_depth),
    .window_low   (window_low),
    .window_high  (window_high),
    .done         (done),
    .hit          (hit),
    .found_score  (found_score),
    .found_move   (found_move),
    .found_depth  (found_depth)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a lookup in flight");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy still high while a result is shown");

  a_lookup_holds_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_LOOKUP)) |=> busy)
    else $error("lookup accepted without entering the check step");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    hit |-> (found_score != '0))
    else $error("hit reported with a zero score");

endmodule

// File: test/transposition_table_probe_tb.sv
// ----------------------------------------------------------------------------
// transposition_table_probe_tb
// Self-checking bench for the transposition table probe. Store and lookup
// items go through the start/busy handshake. A mirror of the slot table
// predicts every lookup result, and each done strobe is checked against it.
// A short directed part covers the edge cases, then random items follow in
// three phases with different amounts of sender idling.
// ----------------------------------------------------------------------------
module transposition_table_probe_tb;
  import ttp_pkg::*;

  localparam logic [BOUND_W-1:0] BOUND_NONE = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASE_ITEMS = 600;

  typedef struct packed {
    logic               hit;
    logic [SCORE_W-1:0] score;
    logic [MOVE_W-1:0]  move;
    logic [DEPTH_W-1:0] depth;
  } probe_result_t;

  class probe_scoreboard;
    ttp_slot_t     slot_mirror [TABLE_ENTRIES];
    probe_result_t pending_results [$];
    int            errors;

    function new();
      foreach (slot_mirror[i]) slot_mirror[i] = '0;
      errors = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Apply a store to the mirror, or predict the result of a lookup.
    function void note_item(input logic op, input logic [KEY_W-1:0] key,
                            input logic [SCORE_W-1:0] score,
                            input logic [DEPTH_W-1:0] depth,
                            input logic [MOVE_W-1:0] move,
                            input logic [BOUND_W-1:0] bound,
                            input logic [DEPTH_W-1:0] need,
                            input logic signed [SCORE_W-1:0] lo,
                            input logic signed [SCORE_W-1:0] hi);
      logic [INDEX_W-1:0] idx;
      ttp_slot_t          slot;
      logic               usable;
      probe_result_t      res;
      idx = key[INDEX_W-1:0];
      if (op == OP_STORE) begin
        slot.key   = key;
        slot.score = score;
        slot.depth = depth;
        slot.move  = move;
        slot.bound = bound;
        slot_mirror[idx] = slot;
      end else begin
        slot = slot_mirror[idx];
        usable = (slot.key == key) && (slot.depth >= need) && (slot.score != '0);
        case (slot.bound)
          BOUND_EXACT: res.hit = usable;
          BOUND_LOWER: res.hit = usable && ($signed(slot.score) >= hi);
          BOUND_UPPER: res.hit = usable && ($signed(slot.score) <= lo);
          default:     res.hit = 1'b0;
        endcase
        res.score = res.hit ? slot.score : '0;
        res.move  = res.hit ? slot.move  : '0;
        res.depth = res.hit ? slot.depth : '0;
        pending_results.push_back(res);
      end
    endfunction

    task check_result(input logic got_hit, input logic [SCORE_W-1:0] got_score,
                      input logic [MOVE_W-1:0] got_move,
                      input logic [DEPTH_W-1:0] got_depth);
      probe_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no lookup pending");
      end else begin
        want = pending_results.pop_front();
        if (got_hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", got_hit, want.hit));
        if (got_score !== want.score)
          report_mismatch($sformatf("found_score %h, expected %h", got_score, want.score));
        if (got_move !== want.move)
          report_mismatch($sformatf("found_move %h, expected %h", got_move, want.move));
        if (got_depth !== want.depth)
          report_mismatch($sformatf("found_depth %0d, expected %0d", got_depth, want.depth));
      end
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      operation = OP_LOOKUP;
  logic [KEY_W-1:0]          position_key = '0;
  logic signed [SCORE_W-1:0] entry_score = '0;
  logic [DEPTH_W-1:0]        entry_depth = '0;
  logic [MOVE_W-1:0]         entry_move = '0;
  logic [BOUND_W-1:0]        bound_kind = '0;
  logic [DEPTH_W-1:0]        needed_depth = '0;
  logic signed [SCORE_W-1:0] window_low = '0;
  logic signed [SCORE_W-1:0] window_high = '0;
  logic                      done;
  logic                      hit;
  logic signed [SCORE_W-1:0] found_score;
  logic [MOVE_W-1:0]         found_move;
  logic [DEPTH_W-1:0]        found_depth;

  probe_scoreboard sb = new();
  int              idle_pct = 16;
  int              stall_count = 0;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  transposition_table_probe dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .position_key(position_key),
    .entry_score(entry_score), .entry_depth(entry_depth),
    .entry_move(entry_move), .bound_kind(bound_kind),
    .needed_depth(needed_depth), .window_low(window_low),
    .window_high(window_high), .done(done), .hit(hit),
    .found_score(found_score), .found_move(found_move),
    .found_depth(found_depth)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check results before noting the item of the same edge: a result always
  // belongs to an earlier item.
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        sb.check_result(hit, found_score, found_move, found_depth);
      if (start && !busy)
        sb.note_item(operation, position_key, entry_score, entry_depth, entry_move,
                     bound_kind, needed_depth, window_low, window_high);
      if (done || (start && !busy))
        stall_count <= 0;
      else
        stall_count <= stall_count + 1;
    end
  end

  initial begin
    while (stall_count < STALL_LIMIT) @(posedge clk);
    $display("** transposition_table_probe: FAILED **");
    $finish;
  end

  task automatic issue(input logic op, input logic [KEY_W-1:0] key,
                       input logic [SCORE_W-1:0] score, input logic [DEPTH_W-1:0] depth,
                       input logic [MOVE_W-1:0] move, input logic [BOUND_W-1:0] bound,
                       input logic [DEPTH_W-1:0] need, input logic [SCORE_W-1:0] lo,
                       input logic [SCORE_W-1:0] hi);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    position_key <= key;
    entry_score  <= score;
    entry_depth  <= depth;
    entry_move   <= move;
    bound_kind   <= bound;
    needed_depth <= need;
    window_low   <= lo;
    window_high  <= hi;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Favor tiny scores so that window tests land on both sides.
  function automatic logic [SCORE_W-1:0] pick_score();
    int r;
    int v;
    r = $urandom_range(9);
    v = int'($urandom_range(6)) - 3;
    case (r)
      0:       return '0;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3, 4, 5, 6: return v[SCORE_W-1:0];
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return DEPTH_W'($urandom_range(63));
    endcase
  endfunction

  task automatic issue_random();
    logic [KEY_W-1:0]   key;
    logic [BOUND_W-1:0] bound;
    int                 r;
    r = $urandom_range(99);
    key = key_pool[$urandom_range(POOL_SIZE-1)];
    // Flip a tag bit now and then to miss on a live slot, or draw a fresh random key.
    if (r >= 95)
      key = {$urandom, $urandom};
    else if (r >= 85)
      key = key ^ (64'd1 << $urandom_range(KEY_W-1, INDEX_W));
    bound = ($urandom_range(9) == 0) ? BOUND_NONE : BOUND_W'($urandom_range(2));
    issue(($urandom_range(99) < 45) ? OP_STORE : OP_LOOKUP, key, pick_score(),
          pick_depth(), MOVE_W'($urandom), bound, pick_depth(), pick_score(),
          pick_score());
  endtask

  initial begin
    // The last third of the pool aliases onto slots of the first third with new tags.
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (i >= 16)
        key_pool[i][INDEX_W-1:0] = key_pool[i-16][INDEX_W-1:0];
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // cleared slot, key zero
    issue(OP_LOOKUP, 64'h0, 16'h0, 6'd0, 16'h0, BOUND_EXACT, 6'd0, 16'h8000, 16'h7FFF);
    issue(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFF, 6'd63, 16'hFFFF, BOUND_EXACT,
          6'd0, 16'h0, 16'h0);
    issue(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd63, 16'h0, 16'h0);
    issue(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd0, 16'h7FFF, 16'h8000);
    // same slot, other tag
    issue(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd0, 16'h0, 16'h0);
    issue(OP_STORE, 64'h1, 16'h8000, 6'd0, 16'h0, BOUND_LOWER, 6'd0, 16'h0, 16'h0);
    issue(OP_LOOKUP, 64'h1, 16'h0, 6'd0, 16'h0, BOUND_EXACT, 6'd0, 16'h0, 16'h8000);
    issue(OP_LOOKUP, 64'h1, 16'h0, 6'd0, 16'h0, BOUND_EXACT, 6'd1, 16'h0, 16'h8000);
    issue(OP_LOOKUP, 64'h1, 16'h0, 6'd0, 16'h0, BOUND_EXACT, 6'd0, 16'h0, 16'h8001);
    issue(OP_STORE, 64'h8000_0000_0000_0002, 16'd5, 6'd10, 16'h1234, BOUND_UPPER,
          6'd0, 16'h0, 16'h0);
    issue(OP_LOOKUP, 64'h8000_0000_0000_0002, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd10, 16'd5, 16'h0);
    issue(OP_LOOKUP, 64'h8000_0000_0000_0002, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd10, 16'd4, 16'h0);
    issue(OP_LOOKUP, 64'h8000_0000_0000_0002, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd11, 16'h7FFF, 16'h0);
    issue(OP_LOOKUP, 64'h8000_0000_0000_0002, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd0, 16'h7FFF, 16'h0);
    // zero score never hits
    issue(OP_STORE, 64'h3, 16'h0, 6'd63, 16'hAAAA, BOUND_EXACT, 6'd0, 16'h0, 16'h0);
    issue(OP_LOOKUP, 64'h3, 16'h0, 6'd0, 16'h0, BOUND_EXACT, 6'd0, 16'h0, 16'h0);
    // bound kind three never hits
    issue(OP_STORE, 64'h4, 16'd100, 6'd63, 16'h5555, BOUND_NONE, 6'd0, 16'h0, 16'h0);
    issue(OP_LOOKUP, 64'h4, 16'h0, 6'd0, 16'h0, BOUND_EXACT, 6'd0, 16'h7FFF, 16'h8000);
    // lookup fields on a store are don't-care
    issue(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 6'd1, 16'h0F0F, BOUND_UPPER,
          6'd63, 16'h8000, 16'h7FFF);
    issue(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd1, 16'hFFFF, 16'h0);
    // store fields on a lookup are don't-care
    issue(OP_LOOKUP, 64'h8000_0000_0000_0002, 16'h7FFF, 6'd63, 16'hFFFF, BOUND_NONE,
          6'd0, 16'h7FFF, 16'h0);
    // evict slot one with a new tag
    issue(OP_STORE, 64'hABCD_0000_0000_0001, 16'd1, 6'd2, 16'hBEEF, BOUND_EXACT,
          6'd0, 16'h0, 16'h0);
    issue(OP_LOOKUP, 64'h1, 16'h0, 6'd0, 16'h0, BOUND_EXACT, 6'd0, 16'h0, 16'h8000);
    issue(OP_LOOKUP, 64'hABCD_0000_0000_0001, 16'h0, 6'd0, 16'h0, BOUND_EXACT,
          6'd2, 16'h0, 16'h0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 16 : (phase == 1) ? 49 : 0;
      repeat (PHASE_ITEMS) issue_random();
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report_mismatch($sformatf("%0d lookups left without result",
                                   sb.pending_results.size()));
    if (sb.errors == 0)
      $display("** transposition_table_probe: PASSED **");
    else
      $display("** transposition_table_probe: FAILED **");
    $finish;
  end
endmodule
